/* sv/pts_pkg.sv */
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the priority sorted table.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic       KIND_ENROLL = 1'b0;
    localparam logic       KIND_LIST   = 1'b1;

    localparam logic [1:0] ST_ACCEPT   = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_ENTRY    = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [15:0] patient_id;
        logic [1:0]  priority_level;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] entry_id;
        logic [1:0]  entry_level;
        logic        last;
    } rsp_item_t;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  level;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     occ;
        logic     tail;
    } cell_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

endpackage

`default_nettype wire

/* sv/pts_cell.sv */
// ----------------------------------------------------------------------------
// pts_cell
// One slot of the sorted chain: holds, inserts/shifts from the left, or
// rotates from the right (tail wraps to head) during a listing.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_cell
    import pts_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire entry_t     new_entry,
    input  wire entry_t     left_entry,
    input  wire entry_t     right_entry,
    input  wire entry_t     head_entry,
    input  wire logic       f_in,
    output logic            f_out,
    output entry_t          entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // insertion point marker: monotone along a sorted chain
    assign f_out = ctrl.occ ? (entry_reg.level >= new_entry.level) : 1'b1;
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            OP_INSERT:
            begin
                if (f_in)
                    entry_next = left_entry;
                else if (f_out)
                    entry_next = new_entry;
            end
            OP_ROTATE:
            begin
                entry_next = ctrl.tail ? head_entry : right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

/* sv/priority_sorted_table.sv */
// ----------------------------------------------------------------------------
// priority_sorted_table
// Bounded table of (id, level) entries kept sorted by ascending level in a
// chain of compare-and-shift cells; enroll inserts, list streams in order.
// ----------------------------------------------------------------------------
// Enroll: result in the output register the cycle after the item is accepted.
// List: enters the listing state, then one entry per cycle while the receiver
//   does not stall, as the chain rotates its occupied cells past cell 0.
// One item in flight at a time; new items wait while a listing drains.
// Reset clears the entry count and control state; cell contents are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_sorted_table
    import pts_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_item_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_item_t      rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    state_t          state_reg;
    state_t          state_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW-1:0]   idx_reg;
    logic [CW-1:0]   idx_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    rsp_item_t       rsp_reg;
    rsp_item_t       rsp_next;

    cell_op_t        op;
    logic            slot_free;
    logic            list_last;
    entry_t          new_entry;
    entry_t          entries [DEPTH];
    logic [DEPTH-1:0] f_out;

    assign new_entry.id    = req.patient_id;
    assign new_entry.level = req.priority_level;

    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE) || !slot_free;
    assign list_last = (idx_reg == count_reg - CW'(1));
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_ctrl_t ctrl;
        entry_t     left_e;
        entry_t     right_e;
        logic       f_in;

        assign ctrl.op   = op;
        assign ctrl.occ  = CW'(i) < count_reg;
        assign ctrl.tail = CW'(i) == (count_reg - CW'(1));

        if (i == 0)
        begin : g_first
            assign left_e = entries[0];
            assign f_in   = 1'b0;
        end
        else
        begin : g_mid
            assign left_e = entries[i-1];
            assign f_in   = f_out[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_e = entries[i];
        end
        else
        begin : g_inner
            assign right_e = entries[i+1];
        end

        pts_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .head_entry  (entries[0]),
            .f_in        (f_in),
            .f_out       (f_out[i]),
            .entry       (entries[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        op             = OP_HOLD;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && slot_free)
                begin
                    if (req.kind == KIND_ENROLL)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next.entry_id    = '0;
                        rsp_next.entry_level = '0;
                        rsp_next.last        = 1'b1;
                        if (count_reg == CW'(DEPTH))
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            rsp_next.status = ST_ACCEPT;
                            op              = OP_INSERT;
                            count_next      = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        rsp_valid_next       = 1'b1;
                        rsp_next.status      = ST_EMPTY;
                        rsp_next.entry_id    = '0;
                        rsp_next.entry_level = '0;
                        rsp_next.last        = 1'b1;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_LIST;
                    end
                end
            end
            S_LIST:
            begin
                if (slot_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = ST_ENTRY;
                    rsp_next.entry_id    = entries[0].id;
                    rsp_next.entry_level = entries[0].level;
                    rsp_next.last        = list_last;
                    op                   = OP_ROTATE;
                    idx_next             = idx_reg + CW'(1);
                    if (list_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above table depth");

    a_list_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LIST |-> req_stall)
        else $error("item accepted during a listing");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_ENTRY) |-> rsp.last)
        else $error("status-only result without last");

    a_enroll_count: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.kind == KIND_ENROLL
            && count_reg != CW'(DEPTH))
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("enroll did not grow the table");

endmodule

`default_nettype wire

/* dv/priority_sorted_table_test.sv */
// ----------------------------------------------------------------------------
// priority_sorted_table_test
// Self-checking bench for the priority sorted table. A shadow copy of the
// table predicts every response of enroll and list items. Directed items come
// first, then random ones under three mixes of sender idling and receiver
// stalls. Responses are checked field by field in order.
// ----------------------------------------------------------------------------

class triage_shadow;
    logic [15:0]        ids    [pts_pkg::DEPTH_DEFAULT];
    logic [1:0]         levels [pts_pkg::DEPTH_DEFAULT];
    int                 count;
    pts_pkg::rsp_item_t owed[$];
    int                 errors;
    int                 enrolls;
    int                 drops;
    int                 lists;
    int                 checked;

    function void owe(logic [1:0] status, logic [15:0] id, logic [1:0] level, logic last);
        pts_pkg::rsp_item_t r;
        r.status      = status;
        r.entry_id    = id;
        r.entry_level = level;
        r.last        = last;
        owed.push_back(r);
    endfunction

    function void note_request(pts_pkg::req_item_t r);
        int pos;
        if (r.kind == pts_pkg::KIND_ENROLL)
        begin
            enrolls++;
            if (count >= pts_pkg::DEPTH_DEFAULT)
            begin
                drops++;
                owe(pts_pkg::ST_FULL, 16'h0000, 2'd0, 1'b1);
                return;
            end
            pos = count;
            for (int i = 0; i < count; i++)
            begin
                if (pos == count && levels[i] >= r.priority_level)
                    pos = i;
            end
            for (int i = count; i > pos; i--)
            begin
                ids[i]    = ids[i - 1];
                levels[i] = levels[i - 1];
            end
            ids[pos]    = r.patient_id;
            levels[pos] = r.priority_level;
            count++;
            owe(pts_pkg::ST_ACCEPT, 16'h0000, 2'd0, 1'b1);
        end
        else
        begin
            lists++;
            if (count == 0)
                owe(pts_pkg::ST_EMPTY, 16'h0000, 2'd0, 1'b1);
            for (int i = 0; i < count; i++)
                owe(pts_pkg::ST_ENTRY, ids[i], levels[i], (i + 1 == count));
        end
    endfunction

    function void check_response(pts_pkg::rsp_item_t a);
        pts_pkg::rsp_item_t e;
        checked++;
        if (owed.size() == 0)
        begin
            errors++;
            $error("response with none owed: status %0d id %h", a.status, a.entry_id);
            return;
        end
        e = owed.pop_front();
        if (a.status !== e.status)
        begin
            errors++;
            $error("status: expected %0d, actual %0d", e.status, a.status);
        end
        if (a.entry_id !== e.entry_id)
        begin
            errors++;
            $error("entry_id: expected %h, actual %h", e.entry_id, a.entry_id);
        end
        if (a.entry_level !== e.entry_level)
        begin
            errors++;
            $error("entry_level: expected %0d, actual %0d", e.entry_level, a.entry_level);
        end
        if (a.last !== e.last)
        begin
            errors++;
            $error("last: expected %0d, actual %0d", e.last, a.last);
        end
    endfunction
endclass

module priority_sorted_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 50;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    req_item_t req       = '0;
    logic      rsp_stall = 1'b0;
    logic      req_stall;
    logic      rsp_valid;
    rsp_item_t rsp;

    triage_shadow tbl;
    int           idle_pct  = 0;
    int           stall_pct = 0;
    int           cycle_count = 0;

    priority_sorted_table #(
        .DEPTH(DEPTH_DEFAULT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99, 0) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            tbl.note_request(req);
        if (rst_n && rsp_valid && !rsp_stall)
            tbl.check_response(rsp);
    end

    function automatic req_item_t make_req(logic kind, logic [15:0] id, logic [1:0] level);
        req_item_t r;
        r.kind           = kind;
        r.patient_id     = id;
        r.priority_level = level;
        return r;
    endfunction

    task automatic send(req_item_t item);
        if ($urandom_range(99, 0) < idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < idle_pct);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // hold off the sender until every owed response is back
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (tbl.owed.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        req_item_t item;
        int        enroll_pct;
        tbl = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(make_req(KIND_LIST,   16'h0000, 2'd0));
        send(make_req(KIND_ENROLL, 16'h0000, 2'd3));
        send(make_req(KIND_ENROLL, 16'hFFFF, 2'd0));
        send(make_req(KIND_ENROLL, 16'h8001, 2'd1));
        send(make_req(KIND_ENROLL, 16'h00FF, 2'd2));
        send(make_req(KIND_ENROLL, 16'hFF00, 2'd2));
        send(make_req(KIND_LIST,   16'hFFFF, 2'd3));
        send(make_req(KIND_ENROLL, 16'h5A5A, 2'd3));
        send(make_req(KIND_ENROLL, 16'hA5A5, 2'd1));
        send(make_req(KIND_ENROLL, 16'h7FFE, 2'd0));
        send(make_req(KIND_LIST,   16'h1234, 2'd1));
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct  = (phase == 0) ? 7 : (phase == 1) ? 70 : 0;
            stall_pct = (phase == 0) ? 70 : (phase == 1) ? 7 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // fill the table early, then lean toward listings
                enroll_pct = (phase == 0 && n < 20) ? 85 : 45;
                item.kind           = ($urandom_range(99, 0) < enroll_pct) ? KIND_ENROLL
                                                                            : KIND_LIST;
                item.patient_id     = 16'($urandom);
                item.priority_level = 2'($urandom_range(3, 0));
                send(item);
            end
            drain();
        end

        stall_pct = 0;
        repeat (DEPTH_DEFAULT + 8) @(posedge clk);

        $display("run: %0d enrolls (%0d dropped on a full table), %0d listings, %0d responses",
                 tbl.enrolls, tbl.drops, tbl.lists, tbl.checked);
        $display("run: levels 0 to 3, random ids, three idle and stall mixes");
        if (tbl.errors == 0 && tbl.owed.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
